@@ rtl/kwme_pkg.sv @@
package kwme_pkg;

    // Sizing of the run store
    localparam int NUM_RUNS  = 8;
    localparam int RUN_DEPTH = 256;
    localparam int MEM_DEPTH = NUM_RUNS * RUN_DEPTH;

    localparam int RUN_W  = $clog2(NUM_RUNS);
    localparam int SLOT_W = $clog2(RUN_DEPTH);
    localparam int CNT_W  = $clog2(RUN_DEPTH + 1);
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    // Fixed field widths of the request and result
    localparam int OPCODE_W    = 2;
    localparam int RUN_FIELD_W = 3;
    localparam int VALUE_W     = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } kwme_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } kwme_state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic [RUN_FIELD_W-1:0]    run_index;
        logic signed [VALUE_W-1:0] element_value;
    } kwme_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [RUN_FIELD_W-1:0]    source_run;
        logic                      all_empty;
        logic                      load_dropped;
    } kwme_out_t;

    // Access request to the run store
    typedef struct packed {
        logic              wr_en;
        logic [RUN_W-1:0]  wr_run;
        logic [SLOT_W-1:0] wr_slot;
        logic              rd_en;
        logic [RUN_W-1:0]  rd_run;
        logic [SLOT_W-1:0] rd_slot;
    } kwme_mem_req_t;

endpackage

@@ rtl/kwme_run_mem.sv @@
module kwme_run_mem (
    input  logic                                 aclk,
    input  kwme_pkg::kwme_mem_req_t              req,
    input  logic signed [kwme_pkg::VALUE_W-1:0]  wr_data,
    output logic signed [kwme_pkg::VALUE_W-1:0]  rd_data
);

    logic [kwme_pkg::VALUE_W-1:0] mem [kwme_pkg::MEM_DEPTH];
    logic [kwme_pkg::ADDR_W-1:0]  wr_addr;
    logic [kwme_pkg::ADDR_W-1:0]  rd_addr;

    // Form flat addresses: run base plus slot
    assign wr_addr = kwme_pkg::ADDR_W'(req.wr_run) * kwme_pkg::ADDR_W'(kwme_pkg::RUN_DEPTH)
                   + kwme_pkg::ADDR_W'(req.wr_slot);
    assign rd_addr = kwme_pkg::ADDR_W'(req.rd_run) * kwme_pkg::ADDR_W'(kwme_pkg::RUN_DEPTH)
                   + kwme_pkg::ADDR_W'(req.rd_slot);

    // Write one word
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one word, registered
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= $signed(mem[rd_addr]);
        end
    end

endmodule

@@ rtl/k_way_merge_engine.sv @@
// Merge engine for up to eight ascending runs of signed 32-bit values held in a
// 2048-word store (256 words per run). A load request appends its value to one run
// and answers with load_dropped set when that run is full or out of range. A pop
// request walks the run heads one per cycle through a single store read port and
// a single signed comparator, returns the smallest head (lowest run number on a
// tie) and advances that run. A pop over empty runs answers with all_empty set.
// A clear request empties every run and gives no result, as does the unused
// opcode. Requests are taken one at a time; a finished result sits in an output
// register, so the next request can be taken while the consumer stalls. Store
// contents need no initialization after reset.
module k_way_merge_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kwme_pkg::kwme_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kwme_pkg::kwme_out_t  m_data
);

    kwme_pkg::kwme_state_t state_reg;
    kwme_pkg::kwme_state_t state_next;

    logic [kwme_pkg::CNT_W-1:0] head_reg [kwme_pkg::NUM_RUNS];
    logic [kwme_pkg::CNT_W-1:0] fill_reg [kwme_pkg::NUM_RUNS];

    logic [kwme_pkg::RUN_W-1:0] scan_idx_reg;
    logic                       op_pop_reg;
    logic                       found_reg;
    logic                       cand_valid_reg;
    logic                       m_valid_reg;

    logic [kwme_pkg::RUN_W-1:0]         cand_run_reg;
    logic [kwme_pkg::RUN_W-1:0]         best_run_reg;
    logic signed [kwme_pkg::VALUE_W-1:0] best_value_reg;
    logic                               drop_reg;
    kwme_pkg::kwme_out_t                m_data_reg;

    kwme_pkg::kwme_mem_req_t            mem_req;
    logic signed [kwme_pkg::VALUE_W-1:0] rd_data;

    logic                       ld_in_range;
    logic [kwme_pkg::RUN_W-1:0] ld_run;
    logic                       load_ok;
    logic                       scan_nonempty;
    logic                       scan_last;
    logic                       cand_wins;
    logic                       out_free;
    kwme_pkg::kwme_out_t        result;

    kwme_run_mem u_run_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .wr_data (s_data.element_value),
        .rd_data (rd_data)
    );

    // Decode the load target
    assign ld_in_range = 32'(s_data.run_index) < kwme_pkg::NUM_RUNS;
    assign ld_run      = kwme_pkg::RUN_W'(s_data.run_index);
    assign load_ok     = ld_in_range
                       && (fill_reg[ld_run] < kwme_pkg::CNT_W'(kwme_pkg::RUN_DEPTH));

    // Scan position and the shared comparator
    assign scan_nonempty = head_reg[scan_idx_reg] < fill_reg[scan_idx_reg];
    assign scan_last     = scan_idx_reg == kwme_pkg::RUN_W'(kwme_pkg::NUM_RUNS - 1);
    assign cand_wins     = cand_valid_reg && (!found_reg || (rd_data < best_value_reg));
    assign out_free      = !m_valid_reg || m_ready;

    // Build the result from the latched outcome
    always_comb begin
        result.merged_value = (op_pop_reg && found_reg) ? best_value_reg : '0;
        result.source_run   = (op_pop_reg && found_reg)
                            ? kwme_pkg::RUN_FIELD_W'(best_run_reg) : '0;
        result.all_empty    = op_pop_reg && !found_reg;
        result.load_dropped = !op_pop_reg && drop_reg;
    end

    // Sequence the request: next state, handshake and store access
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mem_req    = '0;
        unique case (state_reg)
            kwme_pkg::ST_IDLE: begin
                s_ready        = 1'b1;
                mem_req.wr_run  = ld_run;
                mem_req.wr_slot = fill_reg[ld_run][kwme_pkg::SLOT_W-1:0];
                if (s_valid) begin
                    unique case (s_data.opcode)
                        kwme_pkg::OP_LOAD: begin
                            mem_req.wr_en = load_ok;
                            state_next    = kwme_pkg::ST_DONE;
                        end
                        kwme_pkg::OP_POP: begin
                            state_next = kwme_pkg::ST_SCAN;
                        end
                        default: begin
                            state_next = kwme_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            kwme_pkg::ST_SCAN: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_run  = scan_idx_reg;
                mem_req.rd_slot = head_reg[scan_idx_reg][kwme_pkg::SLOT_W-1:0];
                if (scan_last) begin
                    state_next = kwme_pkg::ST_TAIL;
                end
            end
            kwme_pkg::ST_TAIL: begin
                state_next = kwme_pkg::ST_DONE;
            end
            kwme_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = kwme_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kwme_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers: state, run pointers, scan progress, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= kwme_pkg::ST_IDLE;
            scan_idx_reg   <= '0;
            op_pop_reg     <= 1'b0;
            found_reg      <= 1'b0;
            cand_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < kwme_pkg::NUM_RUNS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // Raise valid on a finished result, drop it once the result is taken
            if (state_reg == kwme_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                kwme_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        op_pop_reg     <= s_data.opcode == kwme_pkg::OP_POP;
                        scan_idx_reg   <= '0;
                        found_reg      <= 1'b0;
                        cand_valid_reg <= 1'b0;
                        if (s_data.opcode == kwme_pkg::OP_LOAD && load_ok) begin
                            fill_reg[ld_run] <= fill_reg[ld_run] + kwme_pkg::CNT_W'(1);
                        end
                        if (s_data.opcode == kwme_pkg::OP_CLEAR) begin
                            for (int i = 0; i < kwme_pkg::NUM_RUNS; i++) begin
                                head_reg[i] <= '0;
                                fill_reg[i] <= '0;
                            end
                        end
                    end
                end
                kwme_pkg::ST_SCAN: begin
                    cand_valid_reg <= scan_nonempty;
                    scan_idx_reg   <= scan_idx_reg + kwme_pkg::RUN_W'(1);
                    if (cand_wins) begin
                        found_reg <= 1'b1;
                    end
                end
                kwme_pkg::ST_TAIL: begin
                    cand_valid_reg <= 1'b0;
                    if (cand_wins) begin
                        found_reg <= 1'b1;
                    end
                end
                kwme_pkg::ST_DONE: begin
                    if (out_free) begin
                        if (op_pop_reg && found_reg) begin
                            head_reg[best_run_reg] <= head_reg[best_run_reg]
                                                    + kwme_pkg::CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers: candidate, best head, drop flag, result
    always_ff @(posedge aclk) begin
        if (state_reg == kwme_pkg::ST_IDLE && s_valid) begin
            drop_reg <= !load_ok;
        end
        if (state_reg == kwme_pkg::ST_SCAN) begin
            cand_run_reg <= scan_idx_reg;
        end
        if ((state_reg == kwme_pkg::ST_SCAN || state_reg == kwme_pkg::ST_TAIL) && cand_wins) begin
            best_run_reg   <= cand_run_reg;
            best_value_reg <= rd_data;
        end
        if (state_reg == kwme_pkg::ST_DONE && out_free) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A popped run must have held an unread entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kwme_pkg::ST_DONE && op_pop_reg && found_reg)
        |-> (head_reg[best_run_reg] < fill_reg[best_run_reg]))
        else $error("pop selected a run with no unread entry");

    // The scan visits runs in order, one per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kwme_pkg::ST_SCAN && !scan_last)
        |=> (state_reg == kwme_pkg::ST_SCAN
             && scan_idx_reg == $past(scan_idx_reg) + kwme_pkg::RUN_W'(1)))
        else $error("run scan skipped or stalled");

    // A load never pushes a run past its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kwme_pkg::ST_IDLE && s_valid && s_data.opcode == kwme_pkg::OP_LOAD
         && ld_in_range)
        |=> (fill_reg[$past(ld_run)] <= kwme_pkg::CNT_W'(kwme_pkg::RUN_DEPTH)))
        else $error("run fill count overflow");

    // A clear leaves the first run empty and returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kwme_pkg::ST_IDLE && s_valid && s_data.opcode == kwme_pkg::OP_CLEAR)
        |=> (fill_reg[0] == '0 && head_reg[0] == '0 && state_reg == kwme_pkg::ST_IDLE))
        else $error("clear did not empty the runs");

endmodule

@@ tb/k_way_merge_engine_tb.sv @@
`timescale 1ns / 100ps

module k_way_merge_engine_tb;

    import kwme_pkg::*;

    // Opcode that the block ignores
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int     REQUEST_TARGET = 1850;
    localparam int     QUIET_LIMIT    = 1000;
    localparam int     SETTLE_CYCLES  = 24;
    localparam longint VALUE_MIN      = -64'sd2147483648;
    localparam longint VALUE_MAX      = 64'sd2147483647;

    // Merge scoreboard: mirror of the run store and the queue of merge results due
    class merge_scoreboard;
        logic signed [VALUE_W-1:0] run_words [NUM_RUNS][RUN_DEPTH];
        int unsigned               head [NUM_RUNS];
        int unsigned               fill [NUM_RUNS];
        kwme_out_t                 merges_due [$];
        int                        errors;

        function new();
            foreach (head[i]) begin
                head[i] = 0;
                fill[i] = 0;
            end
            errors = 0;
        endfunction

        // Advance the mirror by one accepted request and queue its result, if any
        function void note_request(kwme_in_t req);
            kwme_out_t                 res;
            int                        best;
            logic signed [VALUE_W-1:0] best_val;
            logic signed [VALUE_W-1:0] head_val;
            res      = '0;
            best     = -1;
            best_val = '0;
            case (req.opcode)
                OP_LOAD: begin
                    if (req.run_index < NUM_RUNS && fill[req.run_index] < RUN_DEPTH) begin
                        run_words[req.run_index][fill[req.run_index]] = req.element_value;
                        fill[req.run_index]++;
                    end else begin
                        res.load_dropped = 1'b1;
                    end
                    merges_due.push_back(res);
                end
                OP_POP: begin
                    // Strict less-than keeps the lowest run on a tie
                    for (int i = 0; i < NUM_RUNS; i++) begin
                        if (head[i] < fill[i]) begin
                            head_val = run_words[i][head[i]];
                            if (best < 0 || head_val < best_val) begin
                                best     = i;
                                best_val = head_val;
                            end
                        end
                    end
                    if (best < 0) begin
                        res.all_empty = 1'b1;
                    end else begin
                        res.merged_value = best_val;
                        res.source_run   = best[RUN_FIELD_W-1:0];
                        head[best]++;
                    end
                    merges_due.push_back(res);
                end
                OP_CLEAR: begin
                    foreach (head[i]) begin
                        head[i] = 0;
                        fill[i] = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result with the oldest one due
        function void check_result(kwme_out_t got);
            kwme_out_t exp;
            if (merges_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value %0d run %0d empty %0b dropped %0b",
                         $time, got.merged_value, got.source_run, got.all_empty,
                         got.load_dropped);
                return;
            end
            exp = merges_due.pop_front();
            if (got.merged_value !== exp.merged_value) begin
                errors++;
                $display("%0t: merged_value expected %0d got %0d",
                         $time, exp.merged_value, got.merged_value);
            end
            if (got.source_run !== exp.source_run) begin
                errors++;
                $display("%0t: source_run expected %0d got %0d",
                         $time, exp.source_run, got.source_run);
            end
            if (got.all_empty !== exp.all_empty) begin
                errors++;
                $display("%0t: all_empty expected %0b got %0b",
                         $time, exp.all_empty, got.all_empty);
            end
            if (got.load_dropped !== exp.load_dropped) begin
                errors++;
                $display("%0t: load_dropped expected %0b got %0b",
                         $time, exp.load_dropped, got.load_dropped);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    kwme_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    kwme_out_t m_data;

    merge_scoreboard sb;
    bit              steady;
    int              requests_sent;

    k_way_merge_engine uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones, none during a steady stretch
    function automatic int idle_len();
        int k;
        if (steady) return 0;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 85) return $urandom_range(1, 3);
        if (k < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Stall the result channel at random
    initial begin : result_stall
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("k_way_merge_engine_tb: FAIL");
        $finish;
    end

    // Drive one request after a random gap and hold it until accepted
    task automatic send_request(input kwme_in_t req);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        if (req.opcode != OP_UNUSED) requests_sent++;
    endtask

    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [RUN_FIELD_W-1:0] run,
                         input logic signed [VALUE_W-1:0] value);
        kwme_in_t req;
        req.opcode        = op;
        req.run_index     = run;
        req.element_value = value;
        send_request(req);
    endtask

    // Drop valid and hold off until every result due has come back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.merges_due.size() != 0) @(posedge aclk);
    endtask

    // Load ascending runs in interleaved order, then pop them back out
    task automatic merge_batch(input bit deep);
        int     len [NUM_RUNS];
        int     taken [NUM_RUNS];
        longint cur [NUM_RUNS];
        int     step_max;
        int     mode;
        int     remaining;
        int     total;
        int     pops;
        int     r;
        int     start;
        bit     mix;
        logic signed [VALUE_W-1:0] seed_val;
        mode      = $urandom_range(0, 3);
        mix       = ($urandom_range(0, 3) == 0);
        remaining = 0;
        case (mode)
            0:       step_max = 2;
            1:       step_max = 1 << 20;
            2:       step_max = 1 << 26;
            default: step_max = 50;
        endcase
        for (int i = 0; i < NUM_RUNS; i++) begin
            len[i]   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            taken[i] = 0;
            seed_val = $urandom;
            case (mode)
                0:       cur[i] = int'($urandom_range(0, 8)) - 4;
                1:       cur[i] = seed_val;
                2:       cur[i] = VALUE_MIN;
                default: cur[i] = VALUE_MAX - $urandom_range(0, 100);
            endcase
        end
        // Overfill one run so later loads to it get dropped
        if (deep) len[$urandom_range(0, NUM_RUNS - 1)] = RUN_DEPTH + $urandom_range(1, 4);
        foreach (len[i]) remaining += len[i];
        total = remaining;
        while (remaining > 0) begin
            start = $urandom_range(0, NUM_RUNS - 1);
            r     = start;
            for (int k = 0; k < NUM_RUNS; k++) begin
                r = (start + k) % NUM_RUNS;
                if (taken[r] < len[r]) break;
            end
            cur[r] += $urandom_range(0, step_max);
            if (cur[r] > VALUE_MAX) cur[r] = VALUE_MAX;
            issue(OP_LOAD, r[RUN_FIELD_W-1:0], cur[r][VALUE_W-1:0]);
            taken[r]++;
            remaining--;
            if (mix && $urandom_range(0, 4) == 0) begin
                issue(OP_POP, RUN_FIELD_W'($urandom), VALUE_W'($urandom));
            end
        end
        pops = total + $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0) pops = $urandom_range(0, total);
        repeat (pops) issue(OP_POP, RUN_FIELD_W'($urandom), VALUE_W'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            issue(OP_CLEAR, RUN_FIELD_W'($urandom), VALUE_W'($urandom));
        end
    endtask

    // Unordered mix of every opcode with random fields
    task automatic noise_batch();
        repeat ($urandom_range(3, 8)) begin
            issue(OPCODE_W'($urandom_range(0, 3)), RUN_FIELD_W'($urandom),
                  VALUE_W'($urandom));
        end
    endtask

    initial begin
        sb            = new();
        steady        = 1'b0;
        requests_sent = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty pop, ignored opcode, extremes, ties, clear
        issue(OP_POP, 3'd7, -32'sd1);
        issue(OP_UNUSED, 3'd7, -32'sd1);
        issue(OP_LOAD, 3'd0, VALUE_MIN[VALUE_W-1:0]);
        issue(OP_LOAD, 3'd7, VALUE_MAX[VALUE_W-1:0]);
        issue(OP_LOAD, 3'd3, 32'sd0);
        issue(OP_LOAD, 3'd5, -32'sd1);
        issue(OP_LOAD, 3'd1, 32'sd5);
        issue(OP_LOAD, 3'd2, 32'sd5);
        issue(OP_LOAD, 3'd2, 32'sd6);
        issue(OP_LOAD, 3'd6, VALUE_MIN[VALUE_W-1:0]);
        repeat (9) issue(OP_POP, 3'd0, 32'sd0);
        issue(OP_LOAD, 3'd4, VALUE_MAX[VALUE_W-1:0]);
        issue(OP_LOAD, 3'd4, VALUE_MAX[VALUE_W-1:0]);
        issue(OP_CLEAR, 3'd0, 32'sd0);
        issue(OP_POP, 3'd0, 32'sd0);
        wait_results_drained();

        // Random: mostly merge batches, one overfilled run up front
        merge_batch(1'b1);
        while (requests_sent < REQUEST_TARGET) begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0) noise_batch();
            else merge_batch($urandom_range(0, 39) == 0);
            if ($urandom_range(0, 9) == 0) wait_results_drained();
        end
        steady = 1'b0;

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.merges_due.size() == 0) begin
            $display("k_way_merge_engine_tb: PASS");
        end else begin
            $display("k_way_merge_engine_tb: FAIL");
        end
        $finish;
    end

endmodule
